### src/clock_synth_divider_programmer_macros.svh
// assertion helpers, clocked on clk_i, quiet while rst_ni is low
`ifndef CLOCK_SYNTH_DIVIDER_PROGRAMMER_MACROS_SVH
`define CLOCK_SYNTH_DIVIDER_PROGRAMMER_MACROS_SVH

// same-cycle implication
`define CSDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/csdp_pkg.sv
`default_nettype none
package csdp_pkg;

  localparam logic [29:0] PLL_HZ         = 30'd800000000;
  localparam logic [19:0] FRAC_DEN       = 20'hFFFFF;
  localparam logic [27:0] FREQ_MIN       = 28'd1;
  localparam logic [27:0] FREQ_R_LIMIT   = 28'd1000000;
  localparam logic [25:0] XTAL_RESET     = 26'd25000000;
  localparam logic [7:0]  ADDR_PLL_A     = 8'd26;
  localparam logic [7:0]  ADDR_MS_BASE   = 8'd42;
  localparam logic [7:0]  ADDR_PLL_RESET = 8'd177;
  localparam logic [7:0]  ADDR_CLK_CTRL  = 8'd16;
  localparam logic [7:0]  DATA_PLL_RESET = 8'hA0;
  localparam logic [7:0]  DATA_CLK_CTRL  = 8'h4F;
  localparam logic [7:0]  DATA_P3_HIGH   = 8'hFF;
  localparam logic [7:0]  DATA_P3_LOW    = 8'hFF;
  localparam logic [3:0]  DATA_P3_TOP    = 4'hF;
  localparam logic [1:0]  CH_NONE        = 2'd3;
  localparam logic [4:0]  BEAT_LAST      = 5'd17;
  localparam logic [4:0]  BEAT_PLL_RESET = 5'd16;
  localparam logic [4:0]  BEAT_MS_FIRST  = 5'd8;

  typedef struct packed {
    logic [1:0]  ch;
    logic [2:0]  rcode;
    logic [17:0] pll_p1;
    logic [19:0] pll_p2;
    logic [17:0] ms_p1;
    logic [19:0] ms_p2;
  } csdp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } csdp_qstat_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_INT,
    DIV_PREP,
    DIV_FRAC
  } div_state_e;

  typedef enum logic {
    FR_IDLE,
    FR_RUN
  } front_state_e;

endpackage
`default_nettype wire

### src/csdp_div.sv
`default_nettype none
module csdp_div
  import csdp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [27:0] divisor_i,
  output logic             busy_o,
  output logic [29:0]      quot_o,
  output logic [19:0]      frac_o
);

  div_state_e  state_q, state_d;
  logic [27:0] rem_q, rem_step;
  logic [29:0] num_q, num_step;
  logic [29:0] quo_q, quo_step;
  logic [29:0] int_q;
  logic [27:0] dvs_q;
  logic [3:0]  cnt_q;
  logic [47:0] nfrac;

  // three restoring steps per cycle
  always_comb begin
    logic [28:0] t;
    rem_step = rem_q;
    num_step = num_q;
    quo_step = quo_q;
    for (int i = 0; i < 3; i++) begin
      t = {rem_step, num_step[29]};
      num_step = {num_step[28:0], 1'b0};
      if (t >= {1'b0, dvs_q}) begin
        t = t - {1'b0, dvs_q};
        quo_step = {quo_step[28:0], 1'b1};
      end else begin
        quo_step = {quo_step[28:0], 1'b0};
      end
      rem_step = t[27:0];
    end
  end

  // remainder times (2^20 - 1)
  assign nfrac = {rem_q, 20'd0} - {20'd0, rem_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: if (start_i) state_d = DIV_INT;
      DIV_INT:  if (cnt_q == 4'd0) state_d = DIV_PREP;
      DIV_PREP: state_d = DIV_FRAC;
      DIV_FRAC: if (cnt_q == 4'd0) state_d = DIV_IDLE;
      default:  state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          dvs_q <= divisor_i;
          num_q <= PLL_HZ;
          rem_q <= 28'd0;
          quo_q <= 30'd0;
          cnt_q <= 4'd9;
        end
      end
      DIV_INT: begin
        rem_q <= rem_step;
        num_q <= num_step;
        quo_q <= quo_step;
        cnt_q <= cnt_q - 4'd1;
      end
      DIV_PREP: begin
        int_q <= quo_q;
        rem_q <= {1'b0, nfrac[47:21]};
        num_q <= {nfrac[20:0], 9'd0};
        quo_q <= 30'd0;
        cnt_q <= 4'd6;
      end
      DIV_FRAC: begin
        rem_q <= rem_step;
        num_q <= num_step;
        quo_q <= quo_step;
        cnt_q <= cnt_q - 4'd1;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != DIV_IDLE);
  assign quot_o = int_q;
  assign frac_o = quo_q[19:0];

endmodule
`default_nettype wire

### src/csdp_front.sv
`default_nettype none
module csdp_front
  import csdp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [27:0] frequency_hz_i,
  input  wire logic [1:0]  channel_i,
  input  wire logic [25:0] crystal_i,
  input  wire csdp_qstat_t qstat_i,
  output logic             push_o,
  output csdp_entry_t      entry_o
);

  front_state_e state_q, state_d;
  logic [1:0]   ch_q;
  logic [2:0]   rcode_q, rcode;
  logic [27:0]  freq, dvs_f, dvs_x;
  logic         accept, start;
  logic         busy_f, busy_x;
  logic [29:0]  int_f, int_x;
  logic [19:0]  frac_f, frac_x;
  logic [37:0]  enc_pll, enc_ms;

  // p1 low 18 bits and p2 of one divider
  function automatic logic [37:0] enc(input logic [10:0] x, input logic [19:0] y);
    logic [26:0] t;
    logic [6:0]  q;
    logic [20:0] r;
    logic [17:0] p1;
    logic [19:0] p2;
    t = {y, 7'd0};
    q = t[26:20];
    r = {1'b0, t[19:0]} + {14'd0, q};
    if (r >= {1'b0, FRAC_DEN}) begin
      q = q + 7'd1;
      r = r - {1'b0, FRAC_DEN};
    end
    p2 = r[19:0];
    p1 = {x, 7'd0} + {11'd0, q} - 18'd512;
    return {p1, p2};
  endfunction

  assign freq = (frequency_hz_i == 28'd0) ? FREQ_MIN : frequency_hz_i;

  always_comb begin
    rcode = 3'd0;
    if (freq < FREQ_R_LIMIT) begin
      if (freq <= 28'd8000)        rcode = 3'd7;
      else if (freq <= 28'd16000)  rcode = 3'd6;
      else if (freq <= 28'd32000)  rcode = 3'd5;
      else if (freq <= 28'd64000)  rcode = 3'd4;
      else if (freq <= 28'd128000) rcode = 3'd3;
      else if (freq <= 28'd256000) rcode = 3'd2;
      else                         rcode = 3'd1;
    end
  end

  assign dvs_f = freq << rcode;
  assign dvs_x = (crystal_i == 26'd0) ? 28'd1 : {2'b00, crystal_i};

  assign in_stall_o = (state_q != FR_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  // channel three is dropped here
  assign start      = accept && (channel_i != CH_NONE);

  csdp_div u_div_f (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .divisor_i (dvs_f),
    .busy_o    (busy_f),
    .quot_o    (int_f),
    .frac_o    (frac_f)
  );

  csdp_div u_div_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .divisor_i (dvs_x),
    .busy_o    (busy_x),
    .quot_o    (int_x),
    .frac_o    (frac_x)
  );

  assign enc_pll = enc({3'd0, int_x[7:0]}, frac_x);
  assign enc_ms  = enc(int_f[10:0], frac_f);

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    unique case (state_q)
      FR_IDLE: if (start) state_d = FR_RUN;
      FR_RUN: begin
        if (!busy_f && !busy_x && !qstat_i.full) begin
          push_o  = 1'b1;
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      ch_q    <= channel_i;
      rcode_q <= rcode;
    end
  end

  always_comb begin
    entry_o.ch     = ch_q;
    entry_o.rcode  = rcode_q;
    entry_o.pll_p1 = enc_pll[37:20];
    entry_o.pll_p2 = enc_pll[19:0];
    entry_o.ms_p1  = enc_ms[37:20];
    entry_o.ms_p2  = enc_ms[19:0];
  end

endmodule
`default_nettype wire

### src/csdp_queue.sv
`default_nettype none
module csdp_queue
  import csdp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire csdp_entry_t entry_i,
  input  wire logic        pop_i,
  output csdp_entry_t      entry_o,
  output csdp_qstat_t      stat_o
);

  csdp_entry_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  assign entry_o      = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule
`default_nettype wire

### src/csdp_back.sv
`default_nettype none
module csdp_back
  import csdp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire csdp_entry_t entry_i,
  input  wire csdp_qstat_t qstat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       reg_addr_o,
  output logic [7:0]       reg_data_o,
  output logic             last_write_o
);

  logic [4:0]  beat_q;
  logic        valid_q, last_q;
  logic [7:0]  addr_q, data_q;
  logic        load;
  logic [7:0]  addr_d, data_d;
  logic [17:0] p1;
  logic [19:0] p2;
  logic [2:0]  rc;
  logic [7:0]  base;

  assign load  = !qstat_i.empty && (!valid_q || !out_stall_i);
  assign pop_o = load && (beat_q == BEAT_LAST);

  always_comb begin
    if (beat_q < BEAT_MS_FIRST) begin
      p1   = entry_i.pll_p1;
      p2   = entry_i.pll_p2;
      rc   = 3'd0;
      base = ADDR_PLL_A;
    end else begin
      p1   = entry_i.ms_p1;
      p2   = entry_i.ms_p2;
      rc   = entry_i.rcode;
      base = ADDR_MS_BASE + {3'd0, entry_i.ch, 3'd0};
    end
    addr_d = base + {5'd0, beat_q[2:0]};
    case (beat_q[2:0])
      3'd0:    data_d = DATA_P3_HIGH;
      3'd1:    data_d = DATA_P3_LOW;
      3'd2:    data_d = {1'b0, rc, 2'b00, p1[17:16]};
      3'd3:    data_d = p1[15:8];
      3'd4:    data_d = p1[7:0];
      3'd5:    data_d = {DATA_P3_TOP, p2[19:16]};
      3'd6:    data_d = p2[15:8];
      default: data_d = p2[7:0];
    endcase
    if (beat_q == BEAT_PLL_RESET) begin
      addr_d = ADDR_PLL_RESET;
      data_d = DATA_PLL_RESET;
    end else if (beat_q == BEAT_LAST) begin
      addr_d = ADDR_CLK_CTRL + {6'd0, entry_i.ch};
      data_d = DATA_CLK_CTRL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= 5'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        beat_q  <= (beat_q == BEAT_LAST) ? 5'd0 : beat_q + 5'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q <= addr_d;
      data_q <= data_d;
      last_q <= (beat_q == BEAT_LAST);
    end
  end

  assign out_valid_o  = valid_q;
  assign reg_addr_o   = addr_q;
  assign reg_data_o   = data_q;
  assign last_write_o = last_q;

endmodule
`default_nettype wire

### src/clock_synth_divider_programmer.sv
// channel   dir  handshake                 payload
// in        in   in_valid_i / in_stall_o   frequency_hz_i, channel_i
// out       out  out_valid_o / out_stall_i reg_addr_o, reg_data_o, last_write_o
// cfg       in   apb (psel, penable, ...)  crystal_hz at byte address 0
//
// one request holds the front from the accept cycle through two radix-8 dividers with
// 10 integer steps, a prep step and 7 fraction steps, to a push into a two-entry queue
// that waits while the queue is full; the next request is taken the cycle after the push
// the back sends 18 beats per request, one per cycle while out_stall_i is low
// channel three is dropped on accept, without stalling the input
// reset (rst_ni low) clears the queue and both sequencers, crystal to 25 MHz
`default_nettype none
`include "clock_synth_divider_programmer_macros.svh"
module clock_synth_divider_programmer
  import csdp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [27:0] frequency_hz_i,
  input  wire logic [1:0]  channel_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       reg_addr_o,
  output logic [7:0]       reg_data_o,
  output logic             last_write_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [25:0] crystal_q;
  csdp_entry_t q_in, q_out;
  csdp_qstat_t qstat;
  logic        push, pop;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crystal_q <= XTAL_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      crystal_q <= pwdata[25:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {6'd0, crystal_q};

  csdp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .frequency_hz_i (frequency_hz_i),
    .channel_i      (channel_i),
    .crystal_i      (crystal_q),
    .qstat_i        (qstat),
    .push_o         (push),
    .entry_o        (q_in)
  );

  csdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (q_in),
    .pop_i   (pop),
    .entry_o (q_out),
    .stat_o  (qstat)
  );

  csdp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (q_out),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reg_addr_o   (reg_addr_o),
    .reg_data_o   (reg_data_o),
    .last_write_o (last_write_o)
  );

  `CSDP_ASSERT_IMP(a_last_is_ctrl, out_valid_o && last_write_o, reg_data_o == DATA_CLK_CTRL && (reg_addr_o == 8'd16 || reg_addr_o == 8'd17 || reg_addr_o == 8'd18), "last beat is not a clock control write")
  `CSDP_ASSERT_IMP(a_reset_beat, out_valid_o && reg_addr_o == ADDR_PLL_RESET, reg_data_o == DATA_PLL_RESET && !last_write_o, "pll reset beat malformed")
  `CSDP_ASSERT_NXT(a_drop_ch3, in_valid_i && !in_stall_o && channel_i == CH_NONE, !in_stall_o, "channel three request not dropped")
  `CSDP_ASSERT_IMP(a_no_push_full, push, !qstat.full, "push into full queue")

endmodule
`default_nettype wire
